// File: rtl/core/bfa_pkg.sv
`timescale 1ns / 1ps

package bfa_pkg;

   // fixed widths of the item fields and the count register
   localparam int OPCODE_W = 3;
   localparam int INDEX_W  = 12;
   localparam int COUNT_W  = 13;

   // defaults for the top level parameters
   localparam int DEF_MAX_BITS  = 4096;
   localparam int DEF_WORD_BITS = 64;

   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd4096;

   // opcodes
   localparam logic [OPCODE_W-1:0] OP_SET        = 3'd0;
   localparam logic [OPCODE_W-1:0] OP_CLEAR      = 3'd1;
   localparam logic [OPCODE_W-1:0] OP_TEST       = 3'd2;
   localparam logic [OPCODE_W-1:0] OP_SET_ALL    = 3'd3;
   localparam logic [OPCODE_W-1:0] OP_CLEAR_ALL  = 3'd4;
   localparam logic [OPCODE_W-1:0] OP_FIND_SET   = 3'd5;
   localparam logic [OPCODE_W-1:0] OP_FIND_CLEAR = 3'd6;
   localparam logic [OPCODE_W-1:0] OP_STATUS     = 3'd7;

   // per-word flags from the scan unit
   typedef struct packed {
      logic hit;
      logic zero;
      logic full;
   } scan_flags_type;

   // one result item
   typedef struct packed {
      logic               bit_value;
      logic               found;
      logic [INDEX_W-1:0] found_index;
      logic               all_clear;
      logic               all_set;
      logic               index_error;
   } rsp_item_type;

endpackage

// File: rtl/core/bfa_ifc.sv
`timescale 1ns / 1ps

interface bfa_req_if;
   logic                          valid;
   logic                          ready;
   logic [bfa_pkg::OPCODE_W-1:0]  opcode;
   logic [bfa_pkg::INDEX_W-1:0]   bit_index;

   modport source (output valid, output opcode, output bit_index, input ready);
   modport sink (input valid, input opcode, input bit_index, output ready);
endinterface

interface bfa_rsp_if;
   logic                        valid;
   logic                        ready;
   logic                        bit_value;
   logic                        found;
   logic [bfa_pkg::INDEX_W-1:0] found_index;
   logic                        all_clear;
   logic                        all_set;
   logic                        index_error;

   modport source (output valid, output bit_value, output found, output found_index,
                   output all_clear, output all_set, output index_error, input ready);
   modport sink (input valid, input bit_value, input found, input found_index,
                 input all_clear, input all_set, input index_error, output ready);
endinterface

// File: rtl/core/bfa_ram.sv
`timescale 1ns / 1ps

module bfa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 64
) (
   input  logic                                       clock,
   input  logic                                       wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]                           wr_data,
   input  logic                                       rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0]   rd_addr,
   output logic [WIDTH-1:0]                           rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/bfa_scan.sv
`timescale 1ns / 1ps

module bfa_scan #(
   parameter int WORD_BITS = 64,
   parameter int BASE_W    = 13
) (
   input  logic [WORD_BITS-1:0]          word_data,
   input  logic [BASE_W-1:0]             word_base,
   input  logic [bfa_pkg::COUNT_W-1:0]   count,
   input  logic                          want_set,
   output bfa_pkg::scan_flags_type       flags,
   output logic [$clog2(WORD_BITS)-1:0]  hit_pos
);
   import bfa_pkg::*;

   localparam int POS_W = $clog2(WORD_BITS);
   localparam int SH_W  = $clog2(WORD_BITS) + 1;
   localparam int CMP_W = (BASE_W > COUNT_W ? BASE_W : COUNT_W) + 1;
   localparam logic [WORD_BITS-1:0] ONES = {WORD_BITS{1'b1}};

   logic [CMP_W-1:0]     count_x;
   logic [CMP_W-1:0]     base_x;
   logic [CMP_W-1:0]     rem;
   logic [WORD_BITS-1:0] mask;
   logic [WORD_BITS-1:0] masked;
   logic [WORD_BITS-1:0] cand;
   logic [WORD_BITS-1:0] lowest;

   // bits of this word that lie below the count
   always_comb begin
      count_x = CMP_W'(count);
      base_x  = CMP_W'(word_base);
      rem     = count_x - base_x;
      if (count_x <= base_x) begin
         mask = '0;
      end else if (rem >= CMP_W'(WORD_BITS)) begin
         mask = ONES;
      end else begin
         mask = ONES >> (SH_W'(WORD_BITS) - SH_W'(rem));
      end
   end

   assign masked = word_data & mask;
   assign cand   = want_set ? masked : (~word_data & mask);
   assign lowest = cand & (~cand + WORD_BITS'(1));

   // encode the isolated lowest bit
   always_comb begin
      hit_pos = '0;
      for (int b = 0; b < WORD_BITS; b++) begin
         if (lowest[b]) begin
            hit_pos = hit_pos | POS_W'(b);
         end
      end
   end

   assign flags.hit  = |cand;
   assign flags.zero = (masked == '0);
   assign flags.full = (masked == mask);

endmodule

// File: rtl/core/bitmap_find_first_allocator_core.sv
`timescale 1ns / 1ps

// bit map allocator with find-first: MAX_BITS flags held in a RAM of
// ceil(MAX_BITS / WORD_BITS) words, driven by a small sequencer around one
// shared word scan unit (mask below the count, lowest-bit encode, all-zero and
// all-one compare). one item is taken at a time and gives exactly one result
// item; the result sits in an output register so the next item is accepted
// while it waits. set, clear and test pass through index split, RAM read,
// modify and result, an out-of-range index going straight to the result;
// set all and clear all sweep the RAM, one RAM word write a cycle;
// find first set, find first clear and status read the map one word a cycle
// through the scan unit, a find stopping at its first hit.
// after reset the block writes zeros to all NUM_WORDS RAM words (64 by default)
// and does not accept items meanwhile; csr writes are taken always.
// the count register resets to 4096 and must only be written while idle.
module bitmap_find_first_allocator_core #(
   parameter int MAX_BITS  = bfa_pkg::DEF_MAX_BITS,
   parameter int WORD_BITS = bfa_pkg::DEF_WORD_BITS
) (
   input  logic                         clock,
   input  logic                         reset,
   bfa_req_if.sink                      req_ch,
   bfa_rsp_if.source                    rsp_ch,
   input  logic                         csr_wr_en,
   input  logic [bfa_pkg::COUNT_W-1:0]  csr_wr_data
);
   import bfa_pkg::*;

   localparam int NUM_WORDS = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
   localparam int ADDR_W    = $clog2(NUM_WORDS > 1 ? NUM_WORDS : 2);
   localparam int POS_W     = $clog2(WORD_BITS);
   localparam int BASE_W    = $clog2(NUM_WORDS * WORD_BITS + 1);
   localparam int CNTX_W    = ($clog2(MAX_BITS + 1) > COUNT_W) ?
                              $clog2(MAX_BITS + 1) : COUNT_W;
   // index / WORD_BITS as a multiply by a rounded-up reciprocal, exact for
   // every INDEX_W-bit index
   localparam int DIV_SH    = INDEX_W + $clog2(WORD_BITS);
   localparam int PROD_W    = DIV_SH + INDEX_W + 1;
   localparam int RECIP     = ((2 ** DIV_SH) + WORD_BITS - 1) / WORD_BITS;
   localparam int MULW_W    = INDEX_W + POS_W + 1;
   localparam logic [ADDR_W-1:0]    LAST_ADDR = ADDR_W'(NUM_WORDS - 1);
   localparam logic [WORD_BITS-1:0] ONES      = {WORD_BITS{1'b1}};

   // sequencer states
   localparam logic [2:0] S_FILL   = 3'd0;
   localparam logic [2:0] S_IDLE   = 3'd1;
   localparam logic [2:0] S_ADDR   = 3'd2;
   localparam logic [2:0] S_READ   = 3'd3;
   localparam logic [2:0] S_MODIFY = 3'd4;
   localparam logic [2:0] S_SCAN   = 3'd5;
   localparam logic [2:0] S_DONE   = 3'd6;

   // control state
   logic [2:0]          state_ff,      state_in;
   logic [COUNT_W-1:0]  bits_in_use_ff, bits_in_use_in;
   logic [ADDR_W-1:0]   fill_addr_ff,  fill_addr_in;
   logic                fill_ones_ff,  fill_ones_in;
   logic                fill_resp_ff,  fill_resp_in;
   logic                iss_done_ff,   iss_done_in;
   logic                eval_valid_ff, eval_valid_in;
   logic                rsp_valid_ff,  rsp_valid_in;

   // payload
   logic [OPCODE_W-1:0] op_ff,         op_in;
   logic [INDEX_W-1:0]  idx_ff,        idx_in;
   logic [INDEX_W-1:0]  quot_ff,       quot_in;
   logic [POS_W-1:0]    pos_ff,        pos_in;
   logic [ADDR_W-1:0]   iss_addr_ff,   iss_addr_in;
   logic [BASE_W-1:0]   iss_base_ff,   iss_base_in;
   logic [BASE_W-1:0]   eval_base_ff,  eval_base_in;
   logic                eval_last_ff,  eval_last_in;
   logic                acc_clear_ff,  acc_clear_in;
   logic                acc_set_ff,    acc_set_in;
   rsp_item_type        res_ff,        res_in;
   rsp_item_type        rsp_ff,        rsp_in;

   // ram port
   logic                ram_wr_en;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [WORD_BITS-1:0] ram_wr_data;
   logic                ram_rd_en;
   logic [ADDR_W-1:0]   ram_rd_addr;
   logic [WORD_BITS-1:0] ram_rd_data;

   // misc
   logic [COUNT_W-1:0]  count_eff;
   logic                req_accept;
   logic [PROD_W-1:0]   div_prod;
   logic [MULW_W-1:0]   word_start;
   logic [WORD_BITS-1:0] bit_mask;
   scan_flags_type      scan_flags;
   logic [POS_W-1:0]    scan_pos;

   bfa_ram #(
      .WIDTH (WORD_BITS),
      .DEPTH (NUM_WORDS)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_en   (ram_rd_en),
      .rd_addr (ram_rd_addr),
      .rd_data (ram_rd_data)
   );

   bfa_scan #(
      .WORD_BITS (WORD_BITS),
      .BASE_W    (BASE_W)
   ) u_scan (
      .word_data (ram_rd_data),
      .word_base (eval_base_ff),
      .count     (count_eff),
      .want_set  (op_ff == OP_FIND_SET),
      .flags     (scan_flags),
      .hit_pos   (scan_pos)
   );

   // count clamped to the map size
   assign count_eff = (CNTX_W'(bits_in_use_ff) > CNTX_W'(MAX_BITS)) ?
                      COUNT_W'(MAX_BITS) : bits_in_use_ff;

   assign req_ch.ready = (state_ff == S_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;

   // word number and bit position of a single-bit access
   assign div_prod   = PROD_W'(idx_ff) * PROD_W'(RECIP);
   assign word_start = MULW_W'(quot_ff) * MULW_W'(WORD_BITS);
   assign bit_mask   = WORD_BITS'(1) << pos_ff;

   assign bits_in_use_in = csr_wr_en ? csr_wr_data : bits_in_use_ff;

   always_comb begin
      state_in      = state_ff;
      fill_addr_in  = fill_addr_ff;
      fill_ones_in  = fill_ones_ff;
      fill_resp_in  = fill_resp_ff;
      iss_done_in   = iss_done_ff;
      eval_valid_in = 1'b0;
      rsp_valid_in  = rsp_valid_ff;
      op_in         = op_ff;
      idx_in        = idx_ff;
      quot_in       = quot_ff;
      pos_in        = pos_ff;
      iss_addr_in   = iss_addr_ff;
      iss_base_in   = iss_base_ff;
      eval_base_in  = eval_base_ff;
      eval_last_in  = eval_last_ff;
      acc_clear_in  = acc_clear_ff;
      acc_set_in    = acc_set_ff;
      res_in        = res_ff;
      rsp_in        = rsp_ff;
      ram_wr_en     = 1'b0;
      ram_wr_addr   = fill_addr_ff;
      ram_wr_data   = fill_ones_ff ? ONES : '0;
      ram_rd_en     = 1'b0;
      ram_rd_addr   = iss_addr_ff;

      // result register drains independently of the sequencer
      if (rsp_valid_ff && rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_FILL: begin
            // one word a cycle: reset clearing, set all, clear all
            ram_wr_en = 1'b1;
            if (fill_addr_ff == LAST_ADDR) begin
               res_in   = '0;
               state_in = fill_resp_ff ? S_DONE : S_IDLE;
            end else begin
               fill_addr_in = fill_addr_ff + ADDR_W'(1);
            end
         end
         S_IDLE: begin
            if (req_accept) begin
               op_in  = req_ch.opcode;
               idx_in = req_ch.bit_index;
               res_in = '0;
               case (req_ch.opcode)
                  OP_SET, OP_CLEAR, OP_TEST: begin
                     state_in = S_ADDR;
                  end
                  OP_SET_ALL, OP_CLEAR_ALL: begin
                     fill_addr_in = '0;
                     fill_ones_in = (req_ch.opcode == OP_SET_ALL);
                     fill_resp_in = 1'b1;
                     state_in     = S_FILL;
                  end
                  default: begin
                     // finds and status walk the whole map
                     iss_addr_in  = '0;
                     iss_base_in  = '0;
                     iss_done_in  = 1'b0;
                     acc_clear_in = 1'b1;
                     acc_set_in   = 1'b1;
                     state_in     = S_SCAN;
                  end
               endcase
            end
         end
         S_ADDR: begin
            if (COUNT_W'(idx_ff) >= count_eff) begin
               res_in.index_error = 1'b1;
               state_in           = S_DONE;
            end else begin
               quot_in  = div_prod[DIV_SH +: INDEX_W];
               state_in = S_READ;
            end
         end
         S_READ: begin
            ram_rd_en   = 1'b1;
            ram_rd_addr = ADDR_W'(quot_ff);
            pos_in      = POS_W'(idx_ff - INDEX_W'(word_start));
            state_in    = S_MODIFY;
         end
         S_MODIFY: begin
            ram_wr_addr = ADDR_W'(quot_ff);
            case (op_ff)
               OP_SET: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = ram_rd_data | bit_mask;
               end
               OP_CLEAR: begin
                  ram_wr_en   = 1'b1;
                  ram_wr_data = ram_rd_data & ~bit_mask;
               end
               default: begin
                  res_in.bit_value = ram_rd_data[pos_ff];
               end
            endcase
            state_in = S_DONE;
         end
         S_SCAN: begin
            // issue side: one read a cycle until the last word
            if (!iss_done_ff) begin
               ram_rd_en     = 1'b1;
               ram_rd_addr   = iss_addr_ff;
               eval_valid_in = 1'b1;
               eval_base_in  = iss_base_ff;
               eval_last_in  = (iss_addr_ff == LAST_ADDR);
               if (iss_addr_ff == LAST_ADDR) begin
                  iss_done_in = 1'b1;
               end else begin
                  iss_addr_in = iss_addr_ff + ADDR_W'(1);
                  iss_base_in = iss_base_ff + BASE_W'(WORD_BITS);
               end
            end
            // evaluate side: the word read last cycle
            if (eval_valid_ff) begin
               if (op_ff == OP_STATUS) begin
                  acc_clear_in = acc_clear_ff & scan_flags.zero;
                  acc_set_in   = acc_set_ff & scan_flags.full;
                  if (eval_last_ff) begin
                     res_in.all_clear = acc_clear_ff & scan_flags.zero;
                     res_in.all_set   = acc_set_ff & scan_flags.full;
                     state_in         = S_DONE;
                  end
               end else if (scan_flags.hit) begin
                  res_in.found       = 1'b1;
                  res_in.found_index = INDEX_W'(eval_base_ff + BASE_W'(scan_pos));
                  state_in           = S_DONE;
               end else if (eval_last_ff) begin
                  state_in = S_DONE;
               end
            end
         end
         S_DONE: begin
            // hand over once the output register is free
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in = 1'b1;
               rsp_in       = res_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= S_FILL;
         bits_in_use_ff <= COUNT_RESET;
         fill_addr_ff   <= '0;
         fill_ones_ff   <= 1'b0;
         fill_resp_ff   <= 1'b0;
         iss_done_ff    <= 1'b0;
         eval_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         bits_in_use_ff <= bits_in_use_in;
         fill_addr_ff   <= fill_addr_in;
         fill_ones_ff   <= fill_ones_in;
         fill_resp_ff   <= fill_resp_in;
         iss_done_ff    <= iss_done_in;
         eval_valid_ff  <= eval_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      quot_ff      <= quot_in;
      pos_ff       <= pos_in;
      iss_addr_ff  <= iss_addr_in;
      iss_base_ff  <= iss_base_in;
      eval_base_ff <= eval_base_in;
      eval_last_ff <= eval_last_in;
      acc_clear_ff <= acc_clear_in;
      acc_set_ff   <= acc_set_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.bit_value   = rsp_ff.bit_value;
   assign rsp_ch.found       = rsp_ff.found;
   assign rsp_ch.found_index = rsp_ff.found_index;
   assign rsp_ch.all_clear   = rsp_ff.all_clear;
   assign rsp_ch.all_set     = rsp_ff.all_set;
   assign rsp_ch.index_error = rsp_ff.index_error;

   // store is written only by the fill sweep or a single-bit update
   assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |-> (state_ff == S_FILL || state_ff == S_MODIFY))
      else $error("store written outside fill or modify");

   // a new result appears only when the sequencer hands one over
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_DONE)
      else $error("result raised without completion");

   // scan data is evaluated only for reads issued by the scan
   assert property (@(posedge clock) disable iff (reset)
      eval_valid_ff |-> $past(state_ff) == S_SCAN)
      else $error("scan evaluation without issued read");

   // a reported find lies below the count
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_ff.found) |-> (COUNT_W'(res_ff.found_index) < count_eff))
      else $error("found index beyond count");

   // index errors come only from single-bit operations
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_ff.index_error) |->
         (op_ff == OP_SET || op_ff == OP_CLEAR || op_ff == OP_TEST))
      else $error("index error on a map-wide operation");

endmodule

// File: tb/tb_bitmap_find_first_allocator_core.sv
`timescale 1ns / 1ps

module tb_bitmap_find_first_allocator_core;
   import bfa_pkg::*;

   localparam int MAP_BITS       = DEF_MAX_BITS;
   localparam int QUIET_LIMIT    = 2000;   // cycles with no handshake at all
   localparam int DRAIN_CYCLES   = 100;    // longer than the slowest scan
   localparam int RANDOM_ITEMS   = 1750;
   localparam int NUM_PHASES     = 10;
   localparam int SCRIPT_LEN     = 30;

   // count setting of each random phase; the last one is drawn at random
   localparam int unsigned COUNT_PLAN [NUM_PHASES] =
      '{4096, 64, 1, 65, 4095, 0, 8191, 4097, 129, 0};

   // kind of a row in the directed script
   typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_type;

   // one directed row: arg is the bit index for an item or the count for a csr write;
   // when typed is set the answer below is pushed instead of the computed one
   typedef struct {
      row_kind_type kind;
      logic [2:0]   op;
      int           arg;
      bit           typed;
      rsp_item_type want;
   } script_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [COUNT_W-1:0] csr_wr_data;

   bfa_req_if req_bus ();
   bfa_rsp_if rsp_bus ();

   bitmap_find_first_allocator_core u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // private copy of the flag map and of the count register
   bit [MAP_BITS-1:0]  flag_map;
   logic [COUNT_W-1:0] live_count;

   // answers owed by the block, oldest first
   rsp_item_type answer_fifo [$];

   int  fail_count;
   int  quiet_cycles;
   bit  idle_on;

   // 8 ns clock
   initial clock = 1'b0;
   always #4 clock = ~clock;

   // directed script: extremes of the index, every opcode, out-of-range indexes,
   // a zero count, a count above the map size and a count of one
   script_row_type directed_script [SCRIPT_LEN] = '{
      // fresh map after reset: everything clear
      '{ROW_ITEM, OP_STATUS,        0, 1, '{0, 0, 0, 1, 0, 0}},
      '{ROW_ITEM, OP_FIND_SET,      0, 1, '0},
      '{ROW_ITEM, OP_FIND_CLEAR,    0, 1, '{0, 1, 0, 0, 0, 0}},
      // top bit of the map
      '{ROW_ITEM, OP_SET,        4095, 1, '0},
      '{ROW_ITEM, OP_TEST,       4095, 1, '{1, 0, 0, 0, 0, 0}},
      '{ROW_ITEM, OP_FIND_SET,      0, 1, '{0, 1, 4095, 0, 0, 0}},
      // bottom bit wins the find
      '{ROW_ITEM, OP_SET,           0, 1, '0},
      '{ROW_ITEM, OP_FIND_SET,      0, 1, '{0, 1, 0, 0, 0, 0}},
      // fill the whole map, then punch one hole with alternating index bits
      '{ROW_ITEM, OP_SET_ALL,       0, 1, '0},
      '{ROW_ITEM, OP_STATUS,        0, 1, '{0, 0, 0, 0, 1, 0}},
      '{ROW_ITEM, OP_FIND_CLEAR,    0, 1, '0},
      '{ROW_ITEM, OP_CLEAR,      2730, 1, '0},
      '{ROW_ITEM, OP_FIND_CLEAR,    3, 1, '{0, 1, 2730, 0, 0, 0}},
      // short map: index at the count is out of range
      '{ROW_CFG,  OP_SET,         100, 0, '0},
      '{ROW_ITEM, OP_TEST,        100, 1, '{0, 0, 0, 0, 0, 1}},
      '{ROW_ITEM, OP_CLEAR,        99, 0, '0},
      '{ROW_ITEM, OP_STATUS,        0, 0, '0},
      // zero count: nothing takes part, status reports both
      '{ROW_CFG,  OP_SET,           0, 0, '0},
      '{ROW_ITEM, OP_SET,           0, 1, '{0, 0, 0, 0, 0, 1}},
      '{ROW_ITEM, OP_FIND_CLEAR,    0, 1, '0},
      '{ROW_ITEM, OP_STATUS,        0, 1, '{0, 0, 0, 1, 1, 0}},
      // count beyond the map size is clamped to the map size
      '{ROW_CFG,  OP_SET,        8191, 0, '0},
      '{ROW_ITEM, OP_FIND_CLEAR,    0, 0, '0},
      // single bit map
      '{ROW_CFG,  OP_SET,           1, 0, '0},
      '{ROW_ITEM, OP_CLEAR_ALL,     0, 1, '0},
      '{ROW_ITEM, OP_STATUS,        0, 1, '{0, 0, 0, 1, 0, 0}},
      '{ROW_ITEM, OP_SET,           0, 1, '0},
      '{ROW_ITEM, OP_STATUS,        0, 1, '{0, 0, 0, 0, 1, 0}},
      '{ROW_ITEM, OP_TEST,       4095, 1, '{0, 0, 0, 0, 0, 1}},
      // back to the full map
      '{ROW_CFG,  OP_SET,        4096, 0, '0}
   };

   // number of bits that take part, with the clamp to the map size
   function automatic int counted_bits();
      return (live_count > MAP_BITS) ? MAP_BITS : int'(live_count);
   endfunction

   // applies one item to the private map and returns the answer it owes
   function automatic rsp_item_type bitmap_answer(logic [2:0] op, logic [11:0] idx);
      rsp_item_type ans;
      int n;
      bit want_one;
      ans = '0;
      n = counted_bits();
      case (op)
         OP_SET, OP_CLEAR, OP_TEST: begin
            if (int'(idx) >= n) begin
               // out of range: flag it and leave the map alone
               ans.index_error = 1'b1;
            end else if (op == OP_SET) begin
               flag_map[idx] = 1'b1;
            end else if (op == OP_CLEAR) begin
               flag_map[idx] = 1'b0;
            end else begin
               ans.bit_value = flag_map[idx];
            end
         end
         // whole-map writes reach bits above the count too
         OP_SET_ALL:   flag_map = '1;
         OP_CLEAR_ALL: flag_map = '0;
         OP_FIND_SET, OP_FIND_CLEAR: begin
            want_one = (op == OP_FIND_SET);
            for (int i = 0; i < n && !ans.found; i++) begin
               if (flag_map[i] == want_one) begin
                  ans.found       = 1'b1;
                  ans.found_index = i[11:0];
               end
            end
         end
         default: begin
            // status: both flags hold on an empty count
            ans.all_clear = 1'b1;
            ans.all_set   = 1'b1;
            for (int i = 0; i < n; i++) begin
               if (flag_map[i]) ans.all_clear = 1'b0;
               else ans.all_set = 1'b0;
            end
         end
      endcase
      return ans;
   endfunction

   // offers one item after a random gap and returns, once it is taken, the answer owed
   task automatic send_item(input logic [2:0] op, input logic [11:0] idx,
                            output rsp_item_type owed);
      int gap;
      gap = idle_on ? $urandom_range(0, 7) : 0;
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.opcode    <= op;
      req_bus.bit_index <= idx;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      owed = bitmap_answer(op, idx);
   endtask

   // count register write, only once every owed answer is in
   task automatic write_count(input logic [COUNT_W-1:0] value);
      req_bus.valid <= 1'b0;
      while (answer_fifo.size() != 0) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      csr_wr_en   <= 1'b0;
      live_count = value;
   endtask

   task automatic check_field(input string name, input logic [INDEX_W-1:0] want,
                              input logic [INDEX_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0d, actual %0d", name, want, got);
         fail_count++;
      end
   endtask

   // result side: random stalls on ready, each taken item checked against the oldest answer
   initial begin
      int stall;
      rsp_item_type owed;
      rsp_bus.ready = 1'b0;
      @(posedge clock);
      while (reset) @(posedge clock);
      forever begin
         stall = idle_on ? $urandom_range(0, 7) : 0;
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         @(posedge clock);
         while (!rsp_bus.valid) @(posedge clock);
         if (answer_fifo.size() == 0) begin
            $error("result item with no answer owed");
            fail_count++;
         end else begin
            owed = answer_fifo.pop_front();
            check_field("bit_value",   owed.bit_value,   rsp_bus.bit_value);
            check_field("found",       owed.found,       rsp_bus.found);
            check_field("found_index", owed.found_index, rsp_bus.found_index);
            check_field("all_clear",   owed.all_clear,   rsp_bus.all_clear);
            check_field("all_set",     owed.all_set,     rsp_bus.all_set);
            check_field("index_error", owed.index_error, rsp_bus.index_error);
         end
      end
   end

   // watchdog: a run that stops moving is a failure
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
         end
      end
   end

   // stimulus: reset, directed script, then random phases over several counts
   initial begin
      rsp_item_type owed;
      logic [2:0]   op;
      logic [11:0]  idx;
      logic [COUNT_W-1:0] phase_count;
      int n;
      int pick;
      int per_phase;

      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.opcode    = OP_SET;
      req_bus.bit_index = '0;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      flag_map          = '0;
      live_count        = COUNT_RESET;
      fail_count        = 0;
      quiet_cycles      = 0;
      idle_on           = 1'b1;

      // reset held from time zero, released on a clock edge
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed part; the block's own clearing pass after reset just holds off ready
      foreach (directed_script[i]) begin
         if (directed_script[i].kind == ROW_CFG) begin
            write_count(directed_script[i].arg[COUNT_W-1:0]);
         end else begin
            send_item(directed_script[i].op, directed_script[i].arg[11:0], owed);
            answer_fifo.push_back(directed_script[i].typed ? directed_script[i].want : owed);
         end
      end

      // random part: one phase per count setting, the last one drawn at random
      per_phase = RANDOM_ITEMS / NUM_PHASES;
      for (int p = 0; p < NUM_PHASES; p++) begin
         phase_count = (p == NUM_PHASES - 1) ? COUNT_W'($urandom_range(1, 8191))
                                             : COUNT_W'(COUNT_PLAN[p]);
         write_count(phase_count);
         for (int k = 0; k < per_phase; k++) begin
            // stretches with and without idling on both sides
            if (k % 50 == 0) idle_on = ($urandom_range(0, 3) != 0);
            pick = $urandom_range(0, 99);
            if      (pick < 30) op = OP_SET;
            else if (pick < 52) op = OP_CLEAR;
            else if (pick < 64) op = OP_TEST;
            else if (pick < 67) op = OP_SET_ALL;
            else if (pick < 70) op = OP_CLEAR_ALL;
            else if (pick < 82) op = OP_FIND_SET;
            else if (pick < 94) op = OP_FIND_CLEAR;
            else                op = OP_STATUS;
            // mostly indexes that hit the counted range, some anywhere
            n = counted_bits();
            if (n > 0 && $urandom_range(0, 9) != 0) idx = 12'($urandom_range(0, n - 1));
            else idx = 12'($urandom_range(0, 4095));
            send_item(op, idx, owed);
            answer_fifo.push_back(owed);
         end
      end

      // drain: every owed answer in, then a quiet stretch for stray results
      req_bus.valid <= 1'b0;
      while (answer_fifo.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (fail_count == 0 && answer_fifo.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
